// ----- sv/rcsp_pkg.sv -----
package rcsp_pkg;

    localparam int CSID_W = 17;

    localparam logic [2:0] PH_BH0      = 3'd0;
    localparam logic [2:0] PH_BH1_LAST = 3'd1;
    localparam logic [2:0] PH_BH1_OF3  = 3'd2;
    localparam logic [2:0] PH_BH2      = 3'd3;
    localparam logic [2:0] PH_MH       = 3'd4;
    localparam logic [2:0] PH_EXT      = 3'd5;
    localparam logic [2:0] PH_PAY      = 3'd6;
    localparam logic [2:0] PH_LOAD     = 3'd7;

    localparam logic [1:0]  FMT_FULL   = 2'd0;
    localparam logic [1:0]  FMT_NONE   = 2'd3;
    localparam logic [23:0] TS_MARK    = 24'hFFFFFF;
    localparam logic [5:0]  CSID_TWO   = 6'd0;
    localparam logic [5:0]  CSID_THREE = 6'd1;
    localparam logic [16:0] CSID_BASE  = 17'd64;
    localparam logic [3:0]  EXT_LEN    = 4'd4;

    typedef struct packed {
        logic [23:0] hdr_ts;
        logic [31:0] abs_ts;
        logic [23:0] msg_len;
        logic [7:0]  msg_type;
        logic [31:0] msg_sid;
        logic [23:0] rcvd;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [7:0]        payload_byte;
        logic [CSID_W-1:0] chunk_stream_id;
        logic [7:0]        message_type;
        logic [31:0]       message_stream_id;
        logic [31:0]       abs_timestamp;
        logic [23:0]       message_length;
        logic              first_of_message;
        logic              last_of_message;
        logic              empty_message;
        logic              csid_error;
    } result_t;

    function automatic logic [3:0] mh_len(input logic [1:0] fmt);
        logic [3:0] n;
        unique case (fmt)
            2'd0:    n = 4'd11;
            2'd1:    n = 4'd7;
            2'd2:    n = 4'd3;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- sv/rcsp_table.sv -----
module rcsp_table #(
    parameter int NUM_STREAMS = 64,
    parameter int AW = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output rcsp_pkg::entry_t         rd_data,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  rcsp_pkg::entry_t         wr_data,
    output logic                     clearing
);
    import rcsp_pkg::*;

    entry_t        mem [NUM_STREAMS];
    entry_t        rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clearing_reg;
    logic          clearing_next;
    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(NUM_STREAMS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        we = clearing_reg ? 1'b1 : wr_en;
        wa = clearing_reg ? clr_cnt_reg : wr_addr;
        wd = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// ----- sv/rcsp_parser.sv -----
module rcsp_parser #(
    parameter int NUM_STREAMS = 64,
    parameter int AW = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [23:0]              chunk_size,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               in_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output rcsp_pkg::result_t        result,
    input  logic                     clearing,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  rcsp_pkg::entry_t         rd_data,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output rcsp_pkg::entry_t         wr_data
);
    import rcsp_pkg::*;

    logic [2:0]        phase_reg, phase_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [1:0]        fmt_reg, fmt_next;
    logic [CSID_W-1:0] csid_reg, csid_next;
    logic [31:0]       fs_reg, fs_next;
    logic [23:0]       cbl_reg, cbl_next;
    entry_t            w_reg, w_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;
    logic              skid_valid_reg, skid_valid_next;
    result_t           skid_reg, skid_next;

    logic              out_free;
    logic              out_take;
    logic              acc;
    logic              go;
    logic              known;
    logic              hdr_done;
    logic              ts_apply;
    logic              emit;
    logic [31:0]       ts;
    logic [31:0]       fs1;
    logic [3:0]        c1;
    logic [23:0]       rcvd1;
    logic [23:0]       rem;
    logic [23:0]       cs;
    logic              first;
    logic              last;
    entry_t            e;
    result_t           res;

    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !skid_valid_reg;
    assign in_stall = clearing || !out_free || (phase_reg == PH_LOAD);
    assign acc      = in_valid && !in_stall;
    assign go       = (phase_reg == PH_LOAD) && out_free;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        fmt_next   = fmt_reg;
        csid_next  = csid_reg;
        fs_next    = fs_reg;
        cbl_next   = cbl_reg;
        e          = (phase_reg == PH_LOAD) ? rd_data : w_reg;
        known      = 1'b0;
        hdr_done   = 1'b0;
        ts_apply   = 1'b0;
        emit       = 1'b0;
        ts         = '0;
        fs1        = fs_reg;
        c1         = cnt_reg + 1'b1;
        rcvd1      = '0;
        rem        = '0;
        first      = 1'b0;
        last       = 1'b0;
        res        = '0;
        cs         = (chunk_size == '0) ? 24'd1 : chunk_size;
        wr_en      = 1'b0;
        unique case (phase_reg)
            PH_BH0:
            begin
                if (acc)
                begin
                    fmt_next  = in_byte[7:6];
                    csid_next = CSID_W'(in_byte[5:0]);
                    if (in_byte[5:0] == CSID_TWO)
                    begin
                        phase_next = PH_BH1_LAST;
                    end
                    else if (in_byte[5:0] == CSID_THREE)
                    begin
                        phase_next = PH_BH1_OF3;
                    end
                    else
                    begin
                        known = 1'b1;
                    end
                end
            end
            PH_BH1_LAST:
            begin
                if (acc)
                begin
                    csid_next = CSID_BASE + CSID_W'(in_byte);
                    known     = 1'b1;
                end
            end
            PH_BH1_OF3:
            begin
                if (acc)
                begin
                    csid_next  = CSID_BASE + CSID_W'(in_byte);
                    phase_next = PH_BH2;
                end
            end
            PH_BH2:
            begin
                if (acc)
                begin
                    csid_next = csid_reg + {1'b0, in_byte, 8'b0};
                    known     = 1'b1;
                end
            end
            PH_LOAD:
            begin
                if (go)
                begin
                    wr_en    = 1'b1;
                    cnt_next = '0;
                    fs_next  = '0;
                    if (fmt_reg == FMT_NONE)
                    begin
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MH;
                    end
                end
            end
            PH_MH:
            begin
                if (acc)
                begin
                    wr_en = 1'b1;
                    priority if (cnt_reg < 4'd6)
                    begin
                        fs1 = {fs_reg[23:0], in_byte};
                        if (cnt_reg == 4'd2)
                        begin
                            e.hdr_ts = fs1[23:0];
                            fs1      = '0;
                        end
                        else if (cnt_reg == 4'd5)
                        begin
                            e.msg_len = fs1[23:0];
                            fs1       = '0;
                        end
                    end
                    else if (cnt_reg == 4'd6)
                    begin
                        e.msg_type = in_byte;
                    end
                    else if (cnt_reg < 4'd11)
                    begin
                        fs1 = fs_reg | ({24'b0, in_byte} << {2'(cnt_reg - 4'd7), 3'b0});
                        if (cnt_reg == 4'd10)
                        begin
                            e.msg_sid = fs1;
                            fs1       = '0;
                        end
                    end
                    else
                    begin
                        fs1 = fs_reg;
                    end
                    fs_next  = fs1;
                    cnt_next = c1;
                    if (c1 >= mh_len(fmt_reg))
                    begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_EXT:
            begin
                if (acc)
                begin
                    wr_en    = 1'b1;
                    fs1      = {fs_reg[23:0], in_byte};
                    fs_next  = fs1;
                    cnt_next = c1;
                    if (c1 >= EXT_LEN)
                    begin
                        ts_apply = 1'b1;
                        ts       = fs1;
                    end
                end
            end
            PH_PAY:
            begin
                if (acc)
                begin
                    wr_en  = 1'b1;
                    first  = (e.rcvd == '0);
                    rcvd1  = e.rcvd + 1'b1;
                    last   = (rcvd1 == e.msg_len);
                    e.rcvd = last ? '0 : rcvd1;
                    emit   = 1'b1;
                    res.payload_byte     = in_byte;
                    res.first_of_message = first;
                    res.last_of_message  = last;
                    cbl_next = cbl_reg - 1'b1;
                    if (cbl_next == '0)
                    begin
                        phase_next = PH_BH0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_BH0;
            end
        endcase

        if (known)
        begin
            if (32'(csid_next) >= NUM_STREAMS)
            begin
                emit                = 1'b1;
                res.csid_error      = 1'b1;
                phase_next          = PH_BH0;
            end
            else
            begin
                phase_next = PH_LOAD;
            end
        end

        if (hdr_done)
        begin
            if (e.hdr_ts == TS_MARK)
            begin
                phase_next = PH_EXT;
                cnt_next   = '0;
                fs_next    = '0;
            end
            else
            begin
                ts_apply = 1'b1;
                ts       = {8'b0, e.hdr_ts};
            end
        end

        if (ts_apply)
        begin
            if (fmt_reg == FMT_FULL)
            begin
                e.abs_ts = ts;
            end
            else if (fmt_reg != FMT_NONE)
            begin
                e.abs_ts = e.abs_ts + ts;
            end
            if (e.msg_len == '0)
            begin
                e.rcvd     = '0;
                phase_next = PH_BH0;
                emit       = 1'b1;
                res.first_of_message = 1'b1;
                res.last_of_message  = 1'b1;
                res.empty_message    = 1'b1;
            end
            else
            begin
                if (e.rcvd >= e.msg_len)
                begin
                    e.rcvd = '0;
                end
                rem        = e.msg_len - e.rcvd;
                cbl_next   = (rem < cs) ? rem : cs;
                phase_next = PH_PAY;
            end
        end

        res.chunk_stream_id = csid_next;
        if (!res.csid_error)
        begin
            res.message_type      = e.msg_type;
            res.message_stream_id = e.msg_sid;
            res.abs_timestamp     = e.abs_ts;
            res.message_length    = e.msg_len;
        end

        w_next          = wr_en ? e : w_reg;
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_take)
            begin
                res_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rd_en   = known;
    assign rd_addr = csid_next[AW-1:0];
    assign wr_addr = csid_reg[AW-1:0];
    assign wr_data = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BH0;
            cnt_reg        <= '0;
            fmt_reg        <= '0;
            csid_reg       <= '0;
            fs_reg         <= '0;
            cbl_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            fmt_reg        <= fmt_next;
            csid_reg       <= csid_next;
            fs_reg         <= fs_next;
            cbl_reg        <= cbl_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// ----- sv/rtmp_chunk_stream_parser.sv -----
// Channel   Direction  Handshake          Payload
// cfg       in         APB psel/penable   paddr, pwdata, prdata (peer_chunk_size at 0x0)
// in        in         in_valid/in_stall  in_byte
// out       out        out_valid/out_stall payload_byte, stream fields, flags
//
// One byte per cycle in headers and payload while in_stall is low; each chunk whose
// csid fits the table passes through PH_LOAD for the synchronous stream-table read.
// After reset the stream table is swept to zero entry by entry, with in_stall
// high; configuration writes are taken during the sweep.
// A stalled output transfer keeps one more behind it in a skid register;
// in_stall rises while that skid register is full.
module rtmp_chunk_stream_parser #(
    parameter int NUM_STREAMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic [16:0] chunk_stream_id,
    output logic [7:0]  message_type,
    output logic [31:0] message_stream_id,
    output logic [31:0] abs_timestamp,
    output logic [23:0] message_length,
    output logic        first_of_message,
    output logic        last_of_message,
    output logic        empty_message,
    output logic        csid_error
);
    import rcsp_pkg::*;

    localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam logic REG_CHUNK_SIZE = 1'b0;

    logic [23:0] pcs_reg, pcs_next;
    logic        cfg_wr;
    logic        clearing;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    entry_t      rd_data;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    entry_t      wr_data;
    result_t     result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        pcs_next = pcs_reg;
        if (cfg_wr && (paddr[2] == REG_CHUNK_SIZE))
        begin
            pcs_next = pwdata[23:0];
        end
        prdata = (paddr[2] == REG_CHUNK_SIZE) ? {8'b0, pcs_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcs_reg <= 24'd128;
        end
        else
        begin
            pcs_reg <= pcs_next;
        end
    end

    rcsp_table #(
        .NUM_STREAMS (NUM_STREAMS),
        .AW          (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    rcsp_parser #(
        .NUM_STREAMS (NUM_STREAMS),
        .AW          (AW)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .chunk_size (pcs_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result),
        .clearing   (clearing),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    assign payload_byte      = result.payload_byte;
    assign chunk_stream_id   = result.chunk_stream_id;
    assign message_type      = result.message_type;
    assign message_stream_id = result.message_stream_id;
    assign abs_timestamp     = result.abs_timestamp;
    assign message_length    = result.message_length;
    assign first_of_message  = result.first_of_message;
    assign last_of_message   = result.last_of_message;
    assign empty_message     = result.empty_message;
    assign csid_error        = result.csid_error;

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("input taken during table sweep");

    a_clear_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(in_valid && !in_stall) && !rd_en)
        else $error("table access during sweep");

    a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_message) |->
            (first_of_message && last_of_message && payload_byte == 8'd0 && !csid_error))
        else $error("empty message transfer malformed");

    a_error_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && csid_error) |->
            (!first_of_message && !last_of_message && !empty_message
             && message_length == 24'd0))
        else $error("csid error transfer malformed");

endmodule
